[rtl/fcu_pkg.sv]
// ----------------------------------------------------------------------------
// fcu_pkg: shared types and constants of the filter channel update block.
// Widths of the samples, the accumulators and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package fcu_pkg;
	localparam int NumBits = 62;
	localparam int DenBits = 45;
	localparam int SampleBits = 16;

	// Sequencer steps that the control logic names: the denominator product
	// and the closing step that decides what follows the term.
	localparam logic [4:0] StepDen = 5'd18;
	localparam logic [4:0] StepLast = 5'd19;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_DIV_RE, ST_DIV_IM, ST_OUT
	} fcu_state_t;
endpackage
`default_nettype wire

[rtl/filter_channel_update_core.sv]
// ----------------------------------------------------------------------------
// filter_channel_update_core: least-squares filter update for one channel.
// Accumulates numerator and denominator terms and divides on the last term unless the denominator is zero.
// ----------------------------------------------------------------------------
// Each accepted item is worked through by one shared 34x18 signed multiplier,
// one product per cycle: eight cross products of spectrum and filter, six
// squares for the magnitudes, four numerator products and one denominator
// product, followed by a closing step. An item not marked last then returns
// the sequencer to idle, and only then can the next item be accepted. An
// item marked last then runs two divisions, real part first, on a bit-serial
// divider before loading the output register; when the denominator is zero no
// division is needed and the register is loaded directly. The result item waits in
// the output register, so the next terms are accepted meanwhile; only a further
// result stalls, in its loading step, until the waiting one has been taken.
// s_tready is high only while the sequencer is idle. The accumulators are sized
// for runs of up to 4096 terms and wrap beyond that.
`default_nettype none
module filter_channel_update_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata, lowest bit first: profile_re, profile_im, cs_pos_re, cs_pos_im,
	// ha_pos_re, ha_pos_im, cs_neg_re, cs_neg_im, ha_neg_re, ha_neg_im
	input  wire logic [10*fcu_pkg::SampleBits-1:0] s_tdata,
	input  wire logic         s_tlast,   // last_term
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata, lowest bit first: out_re, out_im
	output logic [63:0]       m_tdata,
	output logic              m_tuser    // zero_denominator
);
	import fcu_pkg::*;

	localparam int W = SampleBits;

	fcu_state_t state_q, state_d;
	logic [4:0] step_q;
	logic signed [W-1:0] x_q [10];
	logic last_q;
	logic signed [NumBits-1:0] nre_q, nim_q;
	logic [DenBits-1:0] den_q;
	// Cross products of spectrum and filter, held for the numerator pass.
	logic signed [2*W+1:0] pr_q, pi_q, qr_q, qi_q;
	// Squared magnitudes of both filter values and of the profile harmonic.
	logic [2*W+1:0] mhp_q, mhn_q, ms_q;
	logic [2*W+1:0] mag_sum;
	logic signed [2*W+1:0] ma;
	logic signed [W+1:0] mb;
	logic signed [3*W+3:0] prod;
	logic div_start, div_done, div_neg;
	logic [62:0] div_dvd;
	logic [31:0] div_quot;
	logic [31:0] re_q;
	logic [63:0] tdata_q;
	logic zero_q, oval_q;
	logic in_accept, out_load;
	logic signed [NumBits-1:0] div_src;

	assign s_tready = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	// The result is loaded once the output register is free or being emptied.
	assign out_load = (state_q == ST_OUT) && (!oval_q || m_tready);
	assign prod = ma * mb;
	// Each squared magnitude is scaled back to 15 fraction bits (Q2.15) before the sum.
	assign mag_sum = (mhp_q >> (W-1)) + (mhn_q >> (W-1));

	// Operand selection for the shared multiplier, one product per step.
	// The numerator is formed as (pr+qr)*sr + (pi-qi)*si for the real part
	// and (pi+qi)*sr + (qr-pr)*si for the imaginary part.
	always_comb begin
		unique case (step_q)
			5'd0:  begin ma = (2*W+2)'(x_q[2]); mb = (W+2)'(x_q[4]); end
			5'd1:  begin ma = (2*W+2)'(x_q[3]); mb = (W+2)'(x_q[5]); end
			5'd2:  begin ma = (2*W+2)'(x_q[2]); mb = (W+2)'(x_q[5]); end
			5'd3:  begin ma = (2*W+2)'(x_q[3]); mb = (W+2)'(x_q[4]); end
			5'd4:  begin ma = (2*W+2)'(x_q[6]); mb = (W+2)'(x_q[8]); end
			5'd5:  begin ma = (2*W+2)'(x_q[7]); mb = (W+2)'(x_q[9]); end
			5'd6:  begin ma = (2*W+2)'(x_q[6]); mb = (W+2)'(x_q[9]); end
			5'd7:  begin ma = (2*W+2)'(x_q[7]); mb = (W+2)'(x_q[8]); end
			5'd8:  begin ma = (2*W+2)'(x_q[4]); mb = (W+2)'(x_q[4]); end
			5'd9:  begin ma = (2*W+2)'(x_q[5]); mb = (W+2)'(x_q[5]); end
			5'd10: begin ma = (2*W+2)'(x_q[8]); mb = (W+2)'(x_q[8]); end
			5'd11: begin ma = (2*W+2)'(x_q[9]); mb = (W+2)'(x_q[9]); end
			5'd12: begin ma = (2*W+2)'(x_q[0]); mb = (W+2)'(x_q[0]); end
			5'd13: begin ma = (2*W+2)'(x_q[1]); mb = (W+2)'(x_q[1]); end
			5'd14: begin ma = pr_q + qr_q; mb = (W+2)'(x_q[0]); end
			5'd15: begin ma = pi_q - qi_q; mb = (W+2)'(x_q[1]); end
			5'd16: begin ma = pi_q + qi_q; mb = (W+2)'(x_q[0]); end
			5'd17: begin ma = qr_q - pr_q; mb = (W+2)'(x_q[1]); end
			StepDen: begin
				ma = $signed(mag_sum);
				mb = $signed((W+2)'(ms_q >> (W-1)));
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_accept) state_d = ST_MUL;
			ST_MUL: if (step_q == StepLast) begin
				if (!last_q) state_d = ST_IDLE;
				else if (den_q == '0) state_d = ST_OUT;
				else begin state_d = ST_DIV_RE; div_start = 1'b1; end
			end
			ST_DIV_RE: if (div_done) begin state_d = ST_DIV_IM; div_start = 1'b1; end
			ST_DIV_IM: if (div_done) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign div_src = (state_q == ST_MUL) ? nre_q : nim_q;
	assign div_neg = div_src[NumBits-1];
	assign div_dvd = {(div_neg ? NumBits'(-div_src) : div_src), 1'b0};

	fcu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(den_q), .neg(div_neg), .done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0; nre_q <= '0; nim_q <= '0; den_q <= '0;
			oval_q <= 1'b0;
		end else begin
			if (out_load) oval_q <= 1'b1;
			else if (m_tvalid && m_tready) oval_q <= 1'b0;
			if (in_accept) step_q <= '0;
			else if (state_q == ST_MUL) step_q <= step_q + 5'd1;
			if (state_q == ST_MUL) begin
				unique case (step_q)
					5'd14, 5'd15: nre_q <= nre_q + NumBits'(prod);
					5'd16, 5'd17: nim_q <= nim_q + NumBits'(prod);
					StepDen: den_q <= den_q + DenBits'(prod);
					default: ;
				endcase
			end
			if (out_load) begin
				nre_q <= '0; nim_q <= '0; den_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			for (int i = 0; i < 10; i++) x_q[i] <= s_tdata[i*W +: W];
			last_q <= s_tlast;
		end
		if (state_q == ST_MUL) begin
			unique case (step_q)
				5'd0:  pr_q <= (2*W+2)'(prod);
				5'd1:  pr_q <= pr_q - (2*W+2)'(prod);
				5'd2:  pi_q <= (2*W+2)'(prod);
				5'd3:  pi_q <= pi_q + (2*W+2)'(prod);
				5'd4:  qr_q <= (2*W+2)'(prod);
				5'd5:  qr_q <= qr_q + (2*W+2)'(prod);
				5'd6:  qi_q <= (2*W+2)'(prod);
				5'd7:  qi_q <= qi_q - (2*W+2)'(prod);
				5'd8:  mhp_q <= (2*W+2)'(prod);
				5'd9:  mhp_q <= mhp_q + (2*W+2)'(prod);
				5'd10: mhn_q <= (2*W+2)'(prod);
				5'd11: mhn_q <= mhn_q + (2*W+2)'(prod);
				5'd12: ms_q <= (2*W+2)'(prod);
				5'd13: ms_q <= ms_q + (2*W+2)'(prod);
				default: ;
			endcase
		end
		if (state_q == ST_DIV_RE && div_done) re_q <= div_quot;
		if (out_load) begin
			zero_q <= (den_q == '0);
			tdata_q <= (den_q == '0) ? 64'd0 : {div_quot, re_q};
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata = tdata_q;
	assign m_tuser = zero_q;
endmodule
`default_nettype wire

[rtl/fcu_div.sv]
// ----------------------------------------------------------------------------
// fcu_div: restoring divider, one quotient bit per cycle.
// Divides a 63-bit magnitude by a 45-bit positive divisor and saturates.
// ----------------------------------------------------------------------------
`default_nettype none
module fcu_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [62:0] dividend,
	input  wire logic [44:0] divisor,
	input  wire logic        neg,
	output logic             done,
	output logic [31:0]      quot
);
	import fcu_pkg::*;

	logic [62:0] q_q;
	logic [45:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [44:0] den_q;
	logic [46:0] trial;
	logic [45:0] shifted;

	// Overflow detection: a quotient above 32'h7FFFFFFF, or above 32'h80000000 when negative, saturates.
	assign shifted = {rem_q[44:0], q_q[62]};
	assign trial = {1'b0, shifted} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd62;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			if (!trial[46]) begin
				rem_q <= trial[45:0];
				q_q <= {q_q[61:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[61:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			if (q_q > 63'h80000000) quot = 32'h80000000;
			else quot = 32'(~q_q[31:0] + 32'd1);
		end else begin
			if (q_q > 63'h7FFFFFFF) quot = 32'h7FFFFFFF;
			else quot = q_q[31:0];
		end
	end
endmodule
`default_nettype wire
